@@ design/ifb_pkg.sv @@
// shared types, constants and helpers for the indexed framebuffer video unit
package ifb_pkg;

    localparam int ADDR_W = 17;
    localparam int CRD_W  = 9;

    localparam int MEM_BYTES_DFLT = 131072;
    localparam int SCREEN_W_DFLT  = 256;
    localparam int SCREEN_H_DFLT  = 224;

    localparam logic [ADDR_W-1:0] PAL_BASE  = 17'h0E000;
    localparam logic [ADDR_W-1:0] SKIP_ADDR = 17'h0FFF0;

    typedef enum logic [3:0] {
        OP_WR8   = 4'd0,
        OP_WR16  = 4'd1,
        OP_RD8   = 4'd2,
        OP_RD16  = 4'd3,
        OP_PLOT  = 4'd4,
        OP_FILL  = 4'd5,
        OP_CLEAR = 4'd6,
        OP_SCAN  = 4'd7,
        OP_EOF   = 4'd8
    } t_op;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    typedef struct packed {
        logic [15:0] read_data;
        logic        render_ok;
    } t_result;

    function automatic logic [CRD_W-1:0] f_clamp(input logic signed [15:0] v,
                                                  input logic [CRD_W-1:0] hi);
        logic signed [15:0] hs;
        hs = $signed({{(16-CRD_W){1'b0}}, hi});
        if (v < 0) begin
            return '0;
        end else if (v > hs) begin
            return hi;
        end else begin
            return v[CRD_W-1:0];
        end
    endfunction

endpackage

@@ design/indexed_framebuffer_ppu.sv @@
// top level of the indexed framebuffer video unit: config, output register, sequencer, memory
//
// A rectangle fill writes one byte per clipped pixel and a screen clear one byte per screen
// pixel. Every byte of video memory goes through a single port of one byte per cycle, and
// one request is in work at a time; a finished result waits in the output register while
// the next request is taken. After reset the memory is cleared one byte per cycle, so no
// request is taken until the clear is done; configuration writes are taken at any time.
module indexed_framebuffer_ppu #(
    parameter int MEM_BYTES = ifb_pkg::MEM_BYTES_DFLT,
    parameter int SCREEN_W  = ifb_pkg::SCREEN_W_DFLT,
    parameter int SCREEN_H  = ifb_pkg::SCREEN_H_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_op,
    input  logic [16:0]        i_address,
    input  logic [15:0]        i_data,
    input  logic signed [15:0] i_x_left,
    input  logic signed [15:0] i_y_top,
    input  logic signed [15:0] i_x_right,
    input  logic signed [15:0] i_y_bottom,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_read_data,
    output logic               o_render_ok,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);
    import ifb_pkg::*;

    logic     r_gfx_en;
    logic     r_out_valid;
    t_result  r_out;
    t_mem_req w_mem_req;
    logic [7:0] w_mem_rdata;
    logic     w_res_valid;
    t_result  w_res;
    logic     w_res_take;

    assign w_res_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gfx_en    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gfx_en <= i_cfg_wdata;
            end
            if (w_res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    ifb_ctrl #(
        .MEM_BYTES (MEM_BYTES),
        .SCREEN_W  (SCREEN_W),
        .SCREEN_H  (SCREEN_H)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_address   (i_address),
        .i_data      (i_data),
        .i_x_left    (i_x_left),
        .i_y_top     (i_y_top),
        .i_x_right   (i_x_right),
        .i_y_bottom  (i_y_bottom),
        .i_gfx_en    (r_gfx_en),
        .o_mem_req   (w_mem_req),
        .i_mem_rdata (w_mem_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take)
    );

    ifb_vram #(
        .MEM_BYTES (MEM_BYTES)
    ) u_vram (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_mem_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out.read_data;
    assign o_render_ok = r_out.render_ok;

endmodule

@@ design/ifb_vram.sv @@
// byte-wide video memory, one access per cycle, registered read data
module ifb_vram #(
    parameter int MEM_BYTES = 131072
) (
    input  logic              i_clk,
    input  ifb_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);
    import ifb_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr[AW-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ifb_ctrl.sv @@
// request sequencer: decodes one request and walks its byte accesses on the video memory
module ifb_ctrl #(
    parameter int MEM_BYTES = 131072,
    parameter int SCREEN_W  = 256,
    parameter int SCREEN_H  = 224
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [3:0]                i_op,
    input  logic [ifb_pkg::ADDR_W-1:0] i_address,
    input  logic [15:0]               i_data,
    input  logic signed [15:0]        i_x_left,
    input  logic signed [15:0]        i_y_top,
    input  logic signed [15:0]        i_x_right,
    input  logic signed [15:0]        i_y_bottom,
    input  logic                      i_gfx_en,
    output ifb_pkg::t_mem_req         o_mem_req,
    input  logic [7:0]                i_mem_rdata,
    output logic                      o_res_valid,
    output ifb_pkg::t_result          o_res,
    input  logic                      i_res_take
);
    import ifb_pkg::*;

    localparam logic [ADDR_W:0]   MemSize = (ADDR_W+1)'(MEM_BYTES);
    localparam logic [ADDR_W-1:0] MemLast = ADDR_W'(MEM_BYTES - 1);
    localparam logic [ADDR_W-1:0] PixLast = ADDR_W'(SCREEN_W * SCREEN_H - 1);
    localparam logic [CRD_W-1:0]  ScrW    = CRD_W'(SCREEN_W);
    localparam logic [CRD_W-1:0]  ScrH    = CRD_W'(SCREEN_H);

    typedef enum logic [9:0] {
        S_INIT = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_EXEC = 10'b0000000100,
        S_S2   = 10'b0000001000,
        S_S3   = 10'b0000010000,
        S_S4   = 10'b0000100000,
        S_S5   = 10'b0001000000,
        S_FILL = 10'b0010000000,
        S_CLR  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;

    t_op               r_op, n_op;
    logic [ADDR_W-1:0] r_a0, n_a0;
    logic [ADDR_W-1:0] r_a1, n_a1;
    logic [15:0]       r_data, n_data;
    logic [CRD_W-1:0]  r_x0, n_x0;
    logic [CRD_W-1:0]  r_x1, n_x1;
    logic [CRD_W-1:0]  r_y1, n_y1;
    logic [CRD_W-1:0]  r_x, n_x;
    logic [CRD_W-1:0]  r_y, n_y;
    logic [ADDR_W-1:0] r_row, n_row;
    logic              r_on, n_on;
    logic [7:0]        r_idx, n_idx;
    logic [15:0]       r_rdata, n_rdata;
    logic              r_rok, n_rok;

    logic [ADDR_W:0]   w_sub;
    logic [ADDR_W-1:0] w_a0;
    logic [CRD_W-1:0]  w_x0;
    logic [CRD_W-1:0]  w_y0;
    logic              w_accept;
    t_mem_req          w_req;

    assign w_sub    = {1'b0, i_address} - MemSize;
    assign w_a0     = ({1'b0, i_address} >= MemSize) ? w_sub[ADDR_W-1:0] : i_address;
    assign w_x0     = f_clamp(i_x_left, ScrW);
    assign w_y0     = f_clamp(i_y_top, ScrH);
    assign w_accept = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_a0    = r_a0;
        n_a1    = r_a1;
        n_data  = r_data;
        n_x0    = r_x0;
        n_x1    = r_x1;
        n_y1    = r_y1;
        n_x     = r_x;
        n_y     = r_y;
        n_row   = r_row;
        n_on    = r_on;
        n_idx   = r_idx;
        n_rdata = r_rdata;
        n_rok   = r_rok;
        w_req   = '{we: 1'b0, addr: r_a0, wdata: 8'h00};

        case (r_state)
            S_INIT: begin
                w_req = '{we: 1'b1, addr: r_cnt, wdata: 8'h00};
                if (r_cnt == MemLast) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                    n_op    = t_op'(i_op);
                    n_a0    = w_a0;
                    n_a1    = (w_a0 == MemLast) ? '0 : w_a0 + 1'b1;
                    n_data  = i_data;
                    n_x0    = w_x0;
                    n_x1    = f_clamp(i_x_right, ScrW);
                    n_y1    = f_clamp(i_y_bottom, ScrH);
                    n_x     = w_x0;
                    n_y     = w_y0;
                    n_row   = ADDR_W'(w_y0) * ADDR_W'(ScrW);
                    n_on    = !i_x_left[15] && (w_x0 != ScrW)
                              && !i_y_top[15] && (w_y0 != ScrH);
                    n_rdata = '0;
                    n_rok   = 1'b0;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_op)
                    OP_WR8: begin
                        w_req = '{we: 1'b1, addr: r_a0, wdata: r_data[7:0]};
                    end
                    OP_WR16: begin
                        w_req   = '{we: 1'b1, addr: r_a0, wdata: r_data[15:8]};
                        n_state = S_S2;
                    end
                    OP_RD8, OP_RD16, OP_SCAN: begin
                        n_state = S_S2;
                    end
                    OP_PLOT: begin
                        w_req = '{we: r_on, addr: r_row + ADDR_W'(r_x0),
                                  wdata: r_data[7:0]};
                    end
                    OP_FILL: begin
                        if ((r_x0 < r_x1) && (r_y < r_y1)) begin
                            n_state = S_FILL;
                        end
                    end
                    OP_CLEAR: begin
                        n_cnt   = '0;
                        n_state = S_CLR;
                    end
                    OP_EOF: begin
                        w_req = '{we: 1'b1, addr: SKIP_ADDR, wdata: 8'h00};
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_S2: begin
                n_state = S_DONE;
                case (r_op)
                    OP_WR16: begin
                        w_req = '{we: 1'b1, addr: r_a1, wdata: r_data[7:0]};
                    end
                    OP_RD8: begin
                        n_rdata = {8'h00, i_mem_rdata};
                    end
                    OP_RD16: begin
                        w_req          = '{we: 1'b0, addr: r_a1, wdata: 8'h00};
                        n_rdata[15:8]  = i_mem_rdata;
                        n_state        = S_S3;
                    end
                    OP_SCAN: begin
                        n_idx   = i_mem_rdata;
                        w_req   = '{we: 1'b0, addr: PAL_BASE + ADDR_W'({i_mem_rdata, 1'b0}),
                                    wdata: 8'h00};
                        n_state = S_S3;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_S3: begin
                n_state = S_DONE;
                case (r_op)
                    OP_RD16: begin
                        n_rdata[7:0] = i_mem_rdata;
                    end
                    OP_SCAN: begin
                        n_rdata[15:8] = i_mem_rdata;
                        w_req         = '{we: 1'b0, addr: PAL_BASE + ADDR_W'({r_idx, 1'b1}),
                                          wdata: 8'h00};
                        n_state       = S_S4;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_S4: begin
                n_rdata[7:0] = i_mem_rdata;
                w_req        = '{we: 1'b0, addr: SKIP_ADDR, wdata: 8'h00};
                n_state      = S_S5;
            end
            S_S5: begin
                n_rok   = (i_mem_rdata == 8'h00) && i_gfx_en;
                n_state = S_DONE;
            end
            S_FILL: begin
                w_req = '{we: 1'b1, addr: r_row + ADDR_W'(r_x), wdata: r_data[7:0]};
                if (r_x + 1'b1 == r_x1) begin
                    n_x   = r_x0;
                    n_y   = r_y + 1'b1;
                    n_row = r_row + ADDR_W'(ScrW);
                    if (r_y + 1'b1 == r_y1) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            S_CLR: begin
                w_req = '{we: 1'b1, addr: r_cnt, wdata: r_data[7:0]};
                if (r_cnt == PixLast) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_a0    <= n_a0;
        r_a1    <= n_a1;
        r_data  <= n_data;
        r_x0    <= n_x0;
        r_x1    <= n_x1;
        r_y1    <= n_y1;
        r_x     <= n_x;
        r_y     <= n_y;
        r_row   <= n_row;
        r_on    <= n_on;
        r_idx   <= n_idx;
        r_rdata <= n_rdata;
        r_rok   <= n_rok;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_mem_req   = w_req;
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{read_data: r_rdata, render_ok: r_rok};

endmodule

@@ tb/ifb_scoreboard.sv @@
// scoreboard for the indexed framebuffer video unit: memory image, result prediction and compare
module ifb_scoreboard
    import ifb_pkg::*;
#(
    parameter int MEM_BYTES = 131072,
    parameter int SCREEN_W  = 256,
    parameter int SCREEN_H  = 224
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [3:0]         i_op,
    input  logic [16:0]        i_address,
    input  logic [15:0]        i_data,
    input  logic signed [15:0] i_x_left,
    input  logic signed [15:0] i_y_top,
    input  logic signed [15:0] i_x_right,
    input  logic signed [15:0] i_y_bottom,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [15:0]        i_read_data,
    input  logic               i_render_ok,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [7:0] vram [MEM_BYTES];
    logic       gfx_enable = 1'b1;
    t_result    due_results [$];
    int         fails = 0;
    int         waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    function automatic int unsigned fold_addr(input int unsigned a);
        int unsigned r;
        r = a & 32'h1FFFF;
        if (r >= MEM_BYTES) r -= MEM_BYTES;
        if (r >= MEM_BYTES) r = 0;
        return r;
    endfunction

    function automatic logic [7:0] peek_byte(input int unsigned a);
        return vram[fold_addr(a)];
    endfunction

    function automatic void poke_byte(input int unsigned a, input logic [7:0] v);
        vram[fold_addr(a)] = v;
    endfunction

    function automatic logic [15:0] peek_word(input int unsigned a);
        return {peek_byte(a), peek_byte(fold_addr(a) + 1)};
    endfunction

    function automatic int clip(input int v, input int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_result run_request(input logic [3:0] op, input logic [16:0] addr,
                                            input logic [15:0] data, input int xl,
                                            input int yt, input int xr, input int yb);
        t_result     res;
        logic [7:0]  colour;
        int unsigned idx;
        int          x0, x1, y0, y1;
        res    = '0;
        colour = data[7:0];
        case (op)
            OP_WR8: begin
                poke_byte(addr, colour);
            end
            OP_WR16: begin
                poke_byte(addr, data[15:8]);
                poke_byte(fold_addr(addr) + 1, data[7:0]);
            end
            OP_RD8: begin
                res.read_data = {8'h00, peek_byte(addr)};
            end
            OP_RD16: begin
                res.read_data = peek_word(addr);
            end
            OP_PLOT: begin
                if (xl >= 0 && xl < SCREEN_W && yt >= 0 && yt < SCREEN_H)
                    poke_byte(yt * SCREEN_W + xl, colour);
            end
            OP_FILL: begin
                x0 = clip(xl, SCREEN_W);
                x1 = clip(xr, SCREEN_W);
                y0 = clip(yt, SCREEN_H);
                y1 = clip(yb, SCREEN_H);
                for (int y = y0; y < y1; y++)
                    for (int x = x0; x < x1; x++)
                        poke_byte(y * SCREEN_W + x, colour);
            end
            OP_CLEAR: begin
                for (int i = 0; i < SCREEN_W * SCREEN_H; i++)
                    poke_byte(i, colour);
            end
            OP_SCAN: begin
                idx           = peek_byte(addr);
                res.read_data = peek_word(PAL_BASE + 2 * idx);
                res.render_ok = (peek_byte(SKIP_ADDR) == 8'h00) && gfx_enable;
            end
            OP_EOF: begin
                poke_byte(SKIP_ADDR, 8'h00);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (vram[k]) vram[k] = 8'h00;
            gfx_enable = 1'b1;
            due_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result read_data %h render_ok %b", $time,
                             i_read_data, i_render_ok);
                end else begin
                    want = due_results.pop_front();
                    if (i_read_data !== want.read_data) begin
                        fails++;
                        $display("%0t: read_data expected %h actual %h", $time,
                                 want.read_data, i_read_data);
                    end
                    if (i_render_ok !== want.render_ok) begin
                        fails++;
                        $display("%0t: render_ok expected %b actual %b", $time,
                                 want.render_ok, i_render_ok);
                    end
                end
            end
            if (i_cfg_we) gfx_enable = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                due_results.push_back(run_request(i_op, i_address, i_data, i_x_left,
                                                  i_y_top, i_x_right, i_y_bottom));
        end
        waiting = due_results.size();
    end

endmodule

@@ tb/tb.sv @@
// testbench top for the indexed framebuffer video unit: clock, reset, stimulus and verdict
module tb;
    import ifb_pkg::*;

    localparam int MEM_BYTES      = 131072;
    localparam int SCREEN_W       = 256;
    localparam int SCREEN_H       = 224;
    localparam int SCREEN_PIXELS  = SCREEN_W * SCREEN_H;
    localparam int WATCHDOG_LIMIT = 600000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 420;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [3:0]         i_op;
    logic [16:0]        i_address;
    logic [15:0]        i_data;
    logic signed [15:0] i_x_left;
    logic signed [15:0] i_y_top;
    logic signed [15:0] i_x_right;
    logic signed [15:0] i_y_bottom;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [15:0]        o_read_data;
    logic               o_render_ok;
    logic               i_cfg_we;
    logic               i_cfg_wdata;

    int fail_count;
    int pending_results;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_items     = 0;
    int random_clears  = 0;
    int hold_count     = 0;
    int idle_cycles    = 0;
    bit hold_armed     = 1'b0;

    indexed_framebuffer_ppu #(
        .MEM_BYTES(MEM_BYTES),
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_address  (i_address),
        .i_data     (i_data),
        .i_x_left   (i_x_left),
        .i_y_top    (i_y_top),
        .i_x_right  (i_x_right),
        .i_y_bottom (i_y_bottom),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_read_data(o_read_data),
        .o_render_ok(o_render_ok),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    ifb_scoreboard #(
        .MEM_BYTES(MEM_BYTES),
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) board (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_address   (i_address),
        .i_data      (i_data),
        .i_x_left    (i_x_left),
        .i_y_top     (i_y_top),
        .i_x_right   (i_x_right),
        .i_y_bottom  (i_y_bottom),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_read_data (o_read_data),
        .i_render_ok (o_render_ok),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending_results)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: one long hold-off when armed, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_armed && hold_count < HOLD_CYCLES) begin
            i_out_stall <= 1'b1;
            hold_count  <= hold_count + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL indexed_framebuffer_ppu");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [3:0] op, input logic [16:0] addr,
                                input logic [15:0] data, input logic signed [15:0] xl,
                                input logic signed [15:0] yt, input logic signed [15:0] xr,
                                input logic signed [15:0] yb);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_address  <= addr;
        i_data     <= data;
        i_x_left   <= xl;
        i_y_top    <= yt;
        i_x_right  <= xr;
        i_y_bottom <= yb;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent_items++;
    endtask

    task automatic access(input logic [3:0] op, input logic [16:0] addr,
                          input logic [15:0] data);
        send_request(op, addr, data, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
    endtask

    task automatic plot_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic [15:0] data);
        send_request(OP_PLOT, 17'($urandom), data, x, y, 16'($urandom), 16'($urandom));
    endtask

    task automatic fill_rect(input logic signed [15:0] xl, input logic signed [15:0] yt,
                             input logic signed [15:0] xr, input logic signed [15:0] yb,
                             input logic [15:0] data);
        send_request(OP_FILL, 17'($urandom), data, xl, yt, xr, yb);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
    endtask

    task automatic set_graphics(input logic en);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [16:0] pick_address();
        case ($urandom_range(7))
            0, 1, 2: return 17'($urandom_range(SCREEN_PIXELS - 1));
            3:       return PAL_BASE + 17'($urandom_range(511));
            4:       return SKIP_ADDR - 17'd2 + 17'($urandom_range(4));
            5:       return 17'h1FFFF - 17'($urandom_range(3));
            default: return 17'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_coord(input int hi);
        if ($urandom_range(19) == 0) return 16'($urandom);
        return 16'($urandom_range(hi + 8) - 4);
    endfunction

    function automatic logic signed [15:0] pick_edge(input logic signed [15:0] from);
        if ($urandom_range(19) == 0) return 16'($urandom);
        return from + 16'($urandom_range(10)) - 16'sd2;
    endfunction

    task automatic random_request();
        int                 kind;
        logic [7:0]         colour;
        logic [3:0]         op;
        logic signed [15:0] x, y;
        kind   = $urandom_range(999);
        colour = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom);
        if (kind < 120) begin
            access(OP_WR16, PAL_BASE + 17'(2 * colour) + 17'($urandom_range(7) == 0),
                   16'($urandom));
        end else if (kind < 260) begin
            plot_pixel(pick_coord(SCREEN_W), pick_coord(SCREEN_H), {8'($urandom), colour});
        end else if (kind < 340) begin
            // palette entry, pixel, optional frame end, then scan of that pixel
            x = 16'($urandom_range(SCREEN_W - 1));
            y = 16'($urandom_range(SCREEN_H - 1));
            access(OP_WR16, PAL_BASE + 17'(2 * colour), 16'($urandom));
            plot_pixel(x, y, {8'($urandom), colour});
            if ($urandom_range(3) == 0) access(OP_EOF, pick_address(), 16'($urandom));
            access(OP_SCAN, 17'(y * SCREEN_W + x), 16'($urandom));
        end else if (kind < 420) begin
            x = pick_coord(SCREEN_W);
            y = pick_coord(SCREEN_H);
            fill_rect(x, y, pick_edge(x), pick_edge(y), {8'($urandom), colour});
        end else if (kind < 560) begin
            access(OP_SCAN, $urandom_range(7) == 0 ? 17'($urandom)
                            : 17'($urandom_range(SCREEN_PIXELS - 1)), 16'($urandom));
        end else if (kind < 660) begin
            access($urandom_range(1) ? OP_RD16 : OP_RD8, pick_address(), 16'($urandom));
        end else if (kind < 760) begin
            access($urandom_range(1) ? OP_WR16 : OP_WR8, pick_address(), 16'($urandom));
        end else if (kind < 820) begin
            access(OP_EOF, pick_address(), 16'($urandom));
        end else if (kind < 870) begin
            access(OP_WR8, SKIP_ADDR, $urandom_range(3) == 0 ? 16'h0000 : 16'($urandom));
        end else if (kind < 900) begin
            send_request(4'($urandom_range(15, 9)), 17'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (kind < 999 || random_clears >= 3) begin
            op = 4'($urandom_range(8));
            if (op == OP_FILL || op == OP_CLEAR) op = OP_SCAN;
            send_request(op, 17'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
        end else begin
            random_clears++;
            access(OP_CLEAR, 17'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = '0;
        i_address   = '0;
        i_data      = '0;
        i_x_left    = '0;
        i_y_top     = '0;
        i_x_right   = '0;
        i_y_bottom  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        access(OP_RD8, 17'h00000, 16'h0000);
        access(OP_WR16, 17'h1FFFF, 16'hA55A);
        access(OP_RD16, 17'h1FFFF, 16'h0000);
        access(OP_RD8, 17'h00000, 16'hFFFF);
        access(OP_WR8, 17'h00000, 16'hC3FF);
        access(OP_WR16, PAL_BASE + 17'h001FE, 16'hFFFF);
        access(OP_SCAN, 17'h00000, 16'h0000);
        access(OP_WR8, SKIP_ADDR, 16'h0080);
        access(OP_SCAN, 17'h00000, 16'h0000);
        access(OP_EOF, 17'h00000, 16'h0000);
        access(OP_SCAN, 17'h00000, 16'h0000);
        plot_pixel(16'sd255, 16'sd223, 16'h007F);
        plot_pixel(16'sd256, 16'sd0, 16'h0011);
        plot_pixel(-16'sd1, 16'sd5, 16'h0012);
        plot_pixel(16'sd0, 16'sd224, 16'h0013);
        plot_pixel(16'sh8000, 16'sh7FFF, 16'hFFFF);
        access(OP_RD16, 17'(SCREEN_PIXELS - 2), 16'h0000);
        fill_rect(16'sd10, 16'sd10, 16'sd5, 16'sd20, 16'h0022);
        fill_rect(16'sd250, 16'sd220, 16'sd300, 16'sd300, 16'h0033);
        fill_rect(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'h0044);
        access(OP_SCAN, 17'h1FFFF, 16'h0000);
        access(OP_CLEAR, 17'h00000, 16'h12AB);
        set_graphics(1'b0);
        access(OP_SCAN, 17'd100, 16'h0000);
        set_graphics(1'b1);
        send_request(4'hF, 17'h1FFFF, 16'hFFFF, -16'sd1, -16'sd1, -16'sd1, -16'sd1);

        for (int phase = 0; phase < 4; phase++) begin
            set_graphics(phase != 1);
            send_idle_pct  = (phase == 1) ? 57 : (phase == 3) ? 19 : 0;
            recv_stall_pct = (phase == 2) ? 57 : (phase == 3) ? 19 : 0;
            if (phase == 0) hold_armed = 1'b1;
            for (int n = sent_items + PHASE_ITEMS; sent_items < n;) random_request();
        end

        drain_results();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS indexed_framebuffer_ppu");
        end else begin
            $display("FAIL indexed_framebuffer_ppu");
        end
        $finish;
    end

endmodule
